// File: sv/nvgs_pkg.sv
// Package with types and constants of the vertex and grid snap block.
package nvgs_pkg;

  localparam int CoordW = 32;
  localparam int StepW  = 31;

  // Input operation codes.
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  // Entity kinds.
  localparam logic [1:0] KIND_LINE   = 2'd0;
  localparam logic [1:0] KIND_CIRCLE = 2'd1;
  localparam logic [1:0] KIND_ARC    = 2'd2;
  localparam logic [1:0] KIND_OTHER  = 2'd3;

  // Result kinds.
  localparam logic [1:0] SNAP_NONE   = 2'd0;
  localparam logic [1:0] SNAP_VERTEX = 2'd1;
  localparam logic [1:0] SNAP_GRID   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_VERTEX_ON = 2'd0;
  localparam logic [1:0] REG_GRID_ON   = 2'd1;
  localparam logic [1:0] REG_STEP      = 2'd2;
  localparam logic [1:0] REG_THRESH    = 2'd3;

  // One table entry as stored in memory.
  typedef struct packed {
    logic [1:0]        kind;
    logic [CoordW-1:0] sx;
    logic [CoordW-1:0] sy;
    logic [CoordW-1:0] ex;
    logic [CoordW-1:0] ey;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_CAND,
    ST_DIFF,
    ST_MUL,
    ST_CMP,
    ST_GRID,
    ST_DIV,
    ST_GFIX,
    ST_OUT
  } state_t;

endpackage

// File: sv/nearest_vertex_or_grid_snap.sv
// Top level of the vertex and grid snap block.
//
// Input items arrive on in_valid/in_ready: a clear empties the entity table,
// an append writes one entity into the table memory (dropped when full), and
// a query produces one result on out_valid/out_ready. A query reads the
// table memory one entry per visit: a read step, then for each candidate a
// setup, difference, square and compare step; a line has three candidates
// (both ends and the midpoint), a circle or arc one, and any other entity
// none, only the setup step. A decision step follows the walk; a grid
// rounding then runs two passes of the 33-step divider, x then y, before
// out_valid. The memory read port and the single squared-distance datapath make the walk serial.
// One item is worked at a time; a finished result waits in the output
// register until it transfers, and the next item is taken no earlier than
// the cycle of that transfer, so a stalled receiver holds off the input.
// Reset empties the table and loads the register defaults: vertex and grid
// snap on, step 256, threshold 512. Table memory is not cleared.
// Configuration writes on cfg_valid/cfg_ready are taken at any time.
module nearest_vertex_or_grid_snap #(
  parameter int MAX_ENTITIES = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 op,
  input  logic [1:0]                 entity_type,
  input  logic signed [31:0]         first_x,
  input  logic signed [31:0]         first_y,
  input  logic signed [31:0]         second_x,
  input  logic signed [31:0]         second_y,
  input  logic signed [31:0]         query_x,
  input  logic signed [31:0]         query_y,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [31:0]         snapped_x,
  output logic signed [31:0]         snapped_y,
  output logic [1:0]                 snap_kind,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [31:0]                cfg_data
);
  import nvgs_pkg::*;

  localparam int AddrW = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
  localparam int CntW  = $clog2(MAX_ENTITIES + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_ENTITIES);

  state_t state, state_next;

  // Configuration registers and the table count.
  logic              vertex_on, grid_on;
  logic [StepW-1:0]  step, thresh;
  logic [CntW-1:0]   count;

  // Query working registers.
  logic [CntW-1:0]   idx;
  logic [1:0]        cand;
  logic signed [31:0] qx, qy, px, py;
  logic [32:0]       ax, ay;
  logic [63:0]       dx2, dy2;
  logic [63:0]       best_d2;
  logic signed [31:0] best_x, best_y;
  logic              hit;
  logic              far;
  logic              axis;
  logic signed [31:0] gx;
  entry_t            rd_entry;

  logic in_fire, out_fire, wr_en, q_fire;
  logic last_cand, last_idx;
  logic div_start, div_done;
  logic [32:0] quot, dvd;
  logic [32:0] qmag;
  logic [63:0] prod;
  logic signed [32:0] sx33, sy33, mx33, my33;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid & in_ready;
  assign out_fire  = out_valid & out_ready;
  assign q_fire    = in_fire && op == OP_QUERY;
  assign wr_en     = in_fire && op == OP_APPEND && count < MaxCnt;

  // Entity table memory.
  nvgs_ram #(.Width(EntryW), .Depth(MAX_ENTITIES)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[AddrW-1:0]),
    .wr_data ({entity_type, first_x, first_y, second_x, second_y}),
    .rd_addr (idx[AddrW-1:0]),
    .rd_data (rd_entry)
  );

  // Grid divider: quotient of (2|v| + step) by 2*step. The y pass is
  // started from the fix-up cycle of the x pass.
  assign qmag = (axis || state == ST_GFIX)
                ? (qy[31] ? 33'(-{qy[31], qy}) : 33'(qy))
                : (qx[31] ? 33'(-{qx[31], qx}) : 33'(qx));
  assign dvd  = 33'({qmag, 1'b0} + {3'b0, step});
  nvgs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd),
    .divisor  ({step, 1'b0}),
    .done     (div_done),
    .quotient (quot)
  );

  // Midpoint of the line, floor of the sum over two.
  assign sx33 = 33'(signed'(rd_entry.sx)) + 33'(signed'(rd_entry.ex));
  assign sy33 = 33'(signed'(rd_entry.sy)) + 33'(signed'(rd_entry.ey));
  assign mx33 = sx33 >>> 1;
  assign my33 = sy33 >>> 1;

  assign last_idx  = (idx + CntW'(1)) >= count;
  assign last_cand = (rd_entry.kind != KIND_LINE) || cand == 2'd2;
  assign prod      = quot[31:0] * {1'b0, step};

  // Rounded grid coordinate, saturated with the sign of the query.
  assign gx = (axis ? qy[31] : qx[31])
              ? ((quot[32] || (prod[63:31] != '0 && prod != 64'h80000000))
                 ? 32'sh80000000 : 32'(-prod[31:0]))
              : ((quot[32] || prod[63:31] != '0) ? 32'sh7fffffff : prod[31:0]);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_fire) begin
          if (vertex_on && count != '0) state_next = ST_READ;
          else                          state_next = ST_GRID;
        end
      end
      ST_READ: state_next = ST_CAND;
      ST_CAND: begin
        if (rd_entry.kind == KIND_LINE || rd_entry.kind == KIND_CIRCLE ||
            rd_entry.kind == KIND_ARC) begin
          state_next = ST_DIFF;
        end else if (last_idx) begin
          state_next = ST_GRID;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_DIFF: state_next = ST_MUL;
      ST_MUL:  state_next = ST_CMP;
      ST_CMP: begin
        if (!last_cand)    state_next = ST_CAND;
        else if (last_idx) state_next = ST_GRID;
        else               state_next = ST_READ;
      end
      ST_GRID: begin
        if (hit || !grid_on || step == '0) state_next = ST_OUT;
        else                               state_next = ST_DIV;
      end
      ST_DIV:  if (div_done) state_next = ST_GFIX;
      ST_GFIX: state_next = axis ? ST_OUT : ST_DIV;
      ST_OUT: begin
        // A query taken with the result transfer starts right away.
        if (out_fire) begin
          if (q_fire) begin
            if (vertex_on && count != '0) state_next = ST_READ;
            else                          state_next = ST_GRID;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    div_start = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_OUT: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
      end
      ST_GRID: div_start = !(hit || !grid_on || step == '0);
      ST_GFIX: div_start = !axis;
      default: ;
    endcase
  end

  // State, table count and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      vertex_on <= 1'b1;
      grid_on   <= 1'b1;
      step      <= StepW'(256);
      thresh    <= StepW'(512);
    end else begin
      state <= state_next;
      if (in_fire && op == OP_CLEAR) count <= '0;
      else if (wr_en)                count <= count + CntW'(1);
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_VERTEX_ON: vertex_on <= cfg_data[0];
          REG_GRID_ON:   grid_on   <= cfg_data[0];
          REG_STEP:      step      <= cfg_data[StepW-1:0];
          REG_THRESH:    thresh    <= cfg_data[StepW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Query datapath.
  always_ff @(posedge clk) begin
    if (q_fire) begin
      qx      <= query_x;
      qy      <= query_y;
      idx     <= '0;
      cand    <= '0;
      hit     <= 1'b0;
      axis    <= 1'b0;
      best_d2 <= {thresh, 1'b0} == '0 ? '0 : 64'(thresh) * 64'(thresh);
      snapped_x <= query_x;
      snapped_y <= query_y;
      snap_kind <= SNAP_NONE;
    end
    unique case (state)
      ST_CAND: begin
        unique case (cand)
          2'd0:    begin px <= rd_entry.sx; py <= rd_entry.sy; end
          2'd1:    begin px <= rd_entry.ex; py <= rd_entry.ey; end
          default: begin px <= mx33[31:0];  py <= my33[31:0];  end
        endcase
        if (!(rd_entry.kind == KIND_LINE || rd_entry.kind == KIND_CIRCLE ||
              rd_entry.kind == KIND_ARC)) begin
          idx <= idx + CntW'(1);
        end
      end
      ST_DIFF: begin
        ax <= (33'(px) - 33'(qx)) ^ {33{px < qx}};
        ay <= (33'(py) - 33'(qy)) ^ {33{py < qy}};
        far <= 1'b0;
      end
      ST_MUL: begin
        // Ones-complement plus correction gives the magnitude.
        dx2 <= {32'd0, ax[31:0] + 32'(px < qx)} * {32'd0, ax[31:0] + 32'(px < qx)};
        dy2 <= {32'd0, ay[31:0] + 32'(py < qy)} * {32'd0, ay[31:0] + 32'(py < qy)};
        far <= (33'(ax + 33'(px < qx)) >= 33'h080000000) ||
               (33'(ay + 33'(py < qy)) >= 33'h080000000);
      end
      ST_CMP: begin
        if (!far && (dx2 + dy2) < best_d2) begin
          best_d2 <= dx2 + dy2;
          best_x  <= px;
          best_y  <= py;
          hit     <= 1'b1;
        end
        if (last_cand) begin
          cand <= '0;
          idx  <= idx + CntW'(1);
        end else begin
          cand <= cand + 2'd1;
        end
      end
      ST_GRID: begin
        if (hit) begin
          snapped_x <= best_x;
          snapped_y <= best_y;
          snap_kind <= SNAP_VERTEX;
        end else if (grid_on && step != '0) begin
          snap_kind <= SNAP_GRID;
        end
      end
      ST_GFIX: begin
        // Store the saturated coordinate of this pass.
        if (axis) snapped_y <= gx;
        else      snapped_x <= gx;
        axis <= 1'b1;
      end
      default: ;
    endcase
  end
endmodule

// File: sv/nvgs_ram.sv
// Generic single-port write, single-port read RAM with registered read.
module nvgs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// File: sv/nvgs_div.sv
// Restoring divider, one quotient bit per cycle.
module nvgs_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [32:0] quotient
);
  logic [32:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [33:0] trial;

  assign trial = {rem, quotient[32]} - {2'b0, divisor};

  // Shift in one dividend bit per cycle and subtract when it fits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= 6'd33;
        rem      <= '0;
        quotient <= dividend;
      end else if (busy) begin
        if (trial[33]) begin
          rem <= {rem[31:0], quotient[32]};
          quotient <= {quotient[31:0], 1'b0};
        end else begin
          rem <= trial[32:0];
          quotient <= {quotient[31:0], 1'b1};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: sv/nvgs_check.sv
// Port checker for the snap block, bound to the top level.
module nvgs_check (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] op,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] snap_kind
);
  import nvgs_pkg::*;

  // A waiting result stays until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  // Result kind is a defined code.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (snap_kind == SNAP_NONE || snap_kind == SNAP_VERTEX ||
                   snap_kind == SNAP_GRID)) else $error("bad snap kind");

  // Only a query makes a result, so a clear or append never raises out_valid.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid && in_valid && in_ready && op != OP_QUERY |=> !out_valid)
    else $error("result without query");

  // No result comes out of reset.
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result after reset");
endmodule

bind nearest_vertex_or_grid_snap nvgs_check u_check (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .op(op),
  .out_valid(out_valid), .out_ready(out_ready), .snap_kind(snap_kind)
);

// File: tb/tb_nearest_vertex_or_grid_snap.sv
// Self-checking testbench for the vertex and grid snap block.
module tb_nearest_vertex_or_grid_snap;
  timeunit 1ns;
  timeprecision 1ps;
  import nvgs_pkg::*;

  localparam int TableDepth = 256;

  typedef struct {
    logic [1:0]         op;
    logic [1:0]         kind;
    logic signed [31:0] fx, fy, sx, sy, qx, qy;
  } item_t;

  typedef struct {
    logic signed [31:0] x, y;
    logic [1:0]         kind;
  } snap_t;

  // A directed row carries a typed-in result when check is set.
  typedef struct {
    item_t it;
    bit    check;
    snap_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] op = '0;
  logic [1:0] entity_type = '0;
  logic signed [31:0] first_x = '0, first_y = '0, second_x = '0, second_y = '0;
  logic signed [31:0] query_x = '0, query_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] snapped_x, snapped_y;
  logic [1:0] snap_kind;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  nearest_vertex_or_grid_snap u_dut (.*);

  always #1 clk = ~clk;

  // Shadow copy of the entity table and the registers.
  logic [1:0]         shadow_kind [TableDepth];
  logic signed [31:0] shadow_sx [TableDepth], shadow_sy [TableDepth];
  logic signed [31:0] shadow_ex [TableDepth], shadow_ey [TableDepth];
  int unsigned        shadow_count = 0;
  bit                 vertex_on = 1'b1, grid_on = 1'b1;
  logic [63:0]        step_val = 64'd256, thresh_val = 64'd512;

  snap_t pending_snaps[$];
  int    mismatches = 0;

  logic [63:0]        best_d2;
  logic signed [63:0] best_x, best_y;
  bit                 have_hit;

  // Keep a candidate if it is strictly nearer than the best so far.
  function automatic void consider(logic signed [63:0] px, py, qx, qy);
    logic signed [63:0] dx, dy;
    logic [63:0] ax, ay, d2;
    dx = px - qx;
    dy = py - qy;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) return;
    d2 = ax * ax + ay * ay;
    if (d2 < best_d2) begin
      best_d2 = d2;
      best_x = px;
      best_y = py;
      have_hit = 1'b1;
    end
  endfunction

  // Round to the nearest step multiple, half away from zero, saturated.
  function automatic logic [31:0] grid_round(logic signed [63:0] v);
    logic [63:0] m, k;
    logic signed [63:0] r;
    m = v < 0 ? -v : v;
    k = (2 * m + step_val) / (2 * step_val);
    r = k * step_val;
    if (v < 0) r = -r;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic snap_t snap_point(logic signed [31:0] qx32, qy32);
    logic signed [63:0] qx, qy, sx, sy, ex, ey;
    snap_t r;
    qx = qx32;
    qy = qy32;
    r.x = qx32;
    r.y = qy32;
    r.kind = SNAP_NONE;
    if (vertex_on) begin
      best_d2 = thresh_val * thresh_val;
      have_hit = 1'b0;
      for (int i = 0; i < shadow_count; i++) begin
        sx = shadow_sx[i]; sy = shadow_sy[i];
        ex = shadow_ex[i]; ey = shadow_ey[i];
        if (shadow_kind[i] == KIND_LINE) begin
          consider(sx, sy, qx, qy);
          consider(ex, ey, qx, qy);
          consider((sx + ex) >>> 1, (sy + ey) >>> 1, qx, qy);
        end else if (shadow_kind[i] == KIND_CIRCLE || shadow_kind[i] == KIND_ARC) begin
          consider(sx, sy, qx, qy);
        end
      end
      if (have_hit) begin
        r.x = best_x[31:0];
        r.y = best_y[31:0];
        r.kind = SNAP_VERTEX;
      end
    end
    if (r.kind == SNAP_NONE && grid_on && step_val != 0) begin
      r.x = grid_round(qx);
      r.y = grid_round(qy);
      r.kind = SNAP_GRID;
    end
    return r;
  endfunction

  // Update the shadow table for one accepted item, queue any expected snap.
  function automatic void apply_item(item_t it, bit typed, snap_t typed_res);
    case (it.op)
      OP_CLEAR: shadow_count = 0;
      OP_APPEND: begin
        if (shadow_count < TableDepth) begin
          shadow_kind[shadow_count] = it.kind;
          shadow_sx[shadow_count] = it.fx;
          shadow_sy[shadow_count] = it.fy;
          shadow_ex[shadow_count] = it.sx;
          shadow_ey[shadow_count] = it.sy;
          shadow_count++;
        end
      end
      OP_QUERY: pending_snaps.push_back(typed ? typed_res : snap_point(it.qx, it.qy));
      default: ;
    endcase
  endfunction

  // Result side: compare each transfer and stall at random.
  int  stall_left = 0;
  int  rx_cycle = 0;
  bit  rx_quiet = 1'b0;
  always @(posedge clk) begin
    snap_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_snaps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected snap result x=%0d y=%0d kind=%0d",
                                         snapped_x, snapped_y, snap_kind);
        end else begin
          want = pending_snaps.pop_front();
          if (want.x !== snapped_x || want.y !== snapped_y || want.kind !== snap_kind) begin
            mismatches++;
            if (mismatches <= 10)
              $display("snap mismatch: expected x=%0d y=%0d kind=%0d, got x=%0d y=%0d kind=%0d",
                       want.x, want.y, want.kind, snapped_x, snapped_y, snap_kind);
          end
        end
      end
      rx_cycle++;
      if (rx_cycle % 700 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
        stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 150)
                                                  : $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Sender gap length: mostly short, a few long, none in burst stretches.
  bit tx_burst = 1'b0;
  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 99) == 0) tx_burst = !tx_burst;
    if (tx_burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  // Present one item and hold it until the transfer; ends at that edge.
  task automatic send_item(item_t it, bit typed, snap_t typed_res);
    op <= it.op;
    entity_type <= it.kind;
    first_x <= it.fx;  first_y <= it.fy;
    second_x <= it.sx; second_y <= it.sy;
    query_x <= it.qx;  query_y <= it.qy;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    apply_item(it, typed, typed_res);
  endtask

  task automatic send_with_gap(item_t it);
    int gap;
    snap_t none;
    none = '{default: '0};
    send_item(it, 1'b0, none);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait for all snaps, then write the four registers back to back.
  task automatic write_regs(logic [31:0] vert, grid, stp, thr);
    logic [31:0] vals [4];
    vals = '{vert, grid, stp, thr};
    in_valid <= 1'b0;
    while (pending_snaps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (i[1:0])
        REG_VERTEX_ON: vertex_on = vals[i][0];
        REG_GRID_ON:   grid_on = vals[i][0];
        REG_STEP:      step_val = {33'd0, vals[i][30:0]};
        default:       thresh_val = {33'd0, vals[i][30:0]};
      endcase
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Coordinate near an anchor, fully random, or at a range end.
  function automatic logic signed [31:0] pick_coord(logic signed [31:0] anchor);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return anchor + $signed($urandom_range(0, 6000)) - 3000;
    if (r < 90) return $urandom;
    return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
  endfunction

  // Query near a stored point, on a grid half step, or anywhere.
  function automatic item_t make_query(logic signed [31:0] anchor);
    item_t it;
    int idx, r, span;
    logic signed [31:0] bx, by;
    logic signed [63:0] hx;
    it = '{op: OP_QUERY, kind: 2'($urandom), fx: $urandom, fy: $urandom, sx: $urandom,
           sy: $urandom, qx: $urandom, qy: $urandom};
    r = $urandom_range(0, 99);
    span = (thresh_val < 4096) ? int'(thresh_val) + 2 : 4096;
    if (r < 60 && shadow_count > 0) begin
      idx = $urandom_range(0, shadow_count - 1);
      case ($urandom_range(0, 2))
        0: begin bx = shadow_sx[idx]; by = shadow_sy[idx]; end
        1: begin bx = shadow_ex[idx]; by = shadow_ey[idx]; end
        default: begin
          hx = (64'(shadow_sx[idx]) + 64'(shadow_ex[idx])) >>> 1;
          bx = hx[31:0];
          hx = (64'(shadow_sy[idx]) + 64'(shadow_ey[idx])) >>> 1;
          by = hx[31:0];
        end
      endcase
      it.qx = bx + $signed($urandom_range(0, 2 * span)) - span;
      it.qy = by + $signed($urandom_range(0, 2 * span)) - span;
    end else if (r < 80 && step_val != 0 && step_val < 100000) begin
      hx = $signed(64'($urandom_range(0, 200))) - 100;
      hx = hx * $signed(step_val) + $signed(step_val / 2);
      it.qx = hx[31:0];
      it.qy = -hx[31:0];
    end else if (r < 90) begin
      it.qx = pick_coord(anchor);
      it.qy = pick_coord(anchor);
    end
    return it;
  endfunction

  function automatic item_t make_append(logic signed [31:0] anchor);
    item_t it;
    it = '{op: OP_APPEND, kind: 2'($urandom), fx: pick_coord(anchor), fy: pick_coord(anchor),
           sx: pick_coord(anchor), sy: pick_coord(anchor), qx: $urandom, qy: $urandom};
    return it;
  endfunction

  function automatic item_t make_item(logic signed [31:0] anchor);
    item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 4 || shadow_count > 40) begin
      it = make_append(anchor);
      it.op = OP_CLEAR;
    end else if (r < 7) begin
      it = make_append(anchor);
      it.op = OP_NOP;
    end else if (r < 52) begin
      it = make_append(anchor);
    end else begin
      it = make_query(anchor);
    end
    return it;
  endfunction

  // Directed rows at reset settings: step 256, threshold 512.
  function automatic row_t q_row(int qx, int qy, bit chk, int ex, int ey, logic [1:0] ek);
    row_t r;
    r.it = '{op: OP_QUERY, kind: KIND_LINE, fx: $urandom, fy: $urandom, sx: $urandom,
             sy: $urandom, qx: qx, qy: qy};
    r.check = chk;
    r.res = '{x: ex, y: ey, kind: ek};
    return r;
  endfunction

  function automatic row_t a_row(logic [1:0] op_c, logic [1:0] k, int fx, fy, sx, sy);
    row_t r;
    r.it = '{op: op_c, kind: k, fx: fx, fy: fy, sx: sx, sy: sy, qx: $urandom, qy: $urandom};
    r.check = 1'b0;
    r.res = '{default: '0};
    return r;
  endfunction

  localparam int IntMax = 32'h7fff_ffff;
  localparam int IntMin = 32'h8000_0000;

  initial begin
    row_t rows[$];
    int n_items;
    logic signed [31:0] anchor;
    item_t it;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows = '{
      q_row(0, 0, 1, 0, 0, SNAP_GRID),
      q_row(384, -384, 1, 512, -512, SNAP_GRID),
      q_row(IntMax, IntMin, 1, IntMax, IntMin, SNAP_GRID),
      a_row(OP_APPEND, KIND_LINE, 1000, 1000, 3000, 1000),
      a_row(OP_APPEND, KIND_CIRCLE, 5000, 5000, $urandom, $urandom),
      a_row(OP_APPEND, KIND_ARC, -7000, -7000, $urandom, $urandom),
      a_row(OP_APPEND, KIND_OTHER, 100, 100, 100, 100),
      q_row(1100, 1000, 1, 1000, 1000, SNAP_VERTEX),
      q_row(2100, 1000, 1, 2000, 1000, SNAP_VERTEX),
      q_row(100, 100, 1, 0, 0, SNAP_GRID),
      q_row(5000, 5511, 1, 5000, 5000, SNAP_VERTEX),
      q_row(5000, 5512, 1, 5120, 5632, SNAP_GRID),
      q_row(-7100, -6950, 0, 0, 0, SNAP_NONE),
      a_row(OP_APPEND, KIND_LINE, IntMin, IntMin, IntMax, IntMax),
      q_row(-1, -1, 1, -1, -1, SNAP_VERTEX),
      q_row(IntMax, IntMax, 1, IntMax, IntMax, SNAP_VERTEX),
      q_row(IntMin, IntMin, 1, IntMin, IntMin, SNAP_VERTEX),
      a_row(OP_NOP, KIND_CIRCLE, 0, 0, 0, 0),
      q_row(2990, 1010, 0, 0, 0, SNAP_NONE),
      a_row(OP_CLEAR, KIND_LINE, 0, 0, 0, 0),
      q_row(-384, 128, 1, -512, 256, SNAP_GRID)
    };
    foreach (rows[i]) send_item(rows[i].it, rows[i].check, rows[i].res);

    // Random phases, each under its own register setting.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: write_regs({$urandom} << 1 | 1, {$urandom} << 1 | 1, 256, 512);
        1: write_regs({$urandom} << 1, {$urandom} << 1 | 1, $urandom_range(1, 5000),
                      $urandom_range(0, 5000));
        2: write_regs(1, 0, 100, 2000);
        3: write_regs(1, 1, 0, 300);
        4: write_regs(1, 1, 32'hffff_ffff, 32'hffff_ffff);
        5: write_regs(0, 0, 1, 0);
        6: write_regs(1, 1, 3, 0);
        default: write_regs($urandom, $urandom, $urandom_range(1, 70000),
                            $urandom_range(0, 8000));
      endcase
      anchor = $urandom;
      if (p == 3) begin
        // Fill the table past capacity, then query the full table.
        for (int i = 0; i < TableDepth + 6; i++) send_with_gap(make_append(anchor));
        for (int i = 0; i < 6; i++) send_with_gap(make_query(anchor));
        it = make_append(anchor);
        it.op = OP_CLEAR;
        send_with_gap(it);
      end
      n_items = (p == 3) ? 40 : 160;
      for (int i = 0; i < n_items; i++) send_with_gap(make_item(anchor));
    end

    in_valid <= 1'b0;
    while (pending_snaps.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_snaps.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Guard against a hang.
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: nearest_vertex_or_grid_snap.f
sv/nvgs_pkg.sv
sv/nvgs_ram.sv
sv/nvgs_div.sv
sv/nearest_vertex_or_grid_snap.sv
sv/nvgs_check.sv
tb/tb_nearest_vertex_or_grid_snap.sv
